// ===== hdl/gti_pkg.sv =====
// ----------------------------------------------------------------------------
// gti_pkg
// Shared types and constants of the grid turtle interpreter: turtle symbols,
// status codes, register indexes, headings, sequencer states and pose layout.
// ----------------------------------------------------------------------------
package gti_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int COORD_W     = 8;
	localparam int SIDE_W      = 9;
	localparam int STEP_W      = 6;
	localparam int INDEX_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 9;

	// Turtle symbols (ASCII)
	localparam logic [7:0] SYM_FWD   = 8'h46;  // F
	localparam logic [7:0] SYM_LEFT  = 8'h2B;  // +
	localparam logic [7:0] SYM_RIGHT = 8'h2D;  // -
	localparam logic [7:0] SYM_PUSH  = 8'h5B;  // [
	localparam logic [7:0] SYM_POP   = 8'h5D;  // ]

	localparam logic CMD_INTERPRET = 1'b0;
	localparam logic CMD_RESTART   = 1'b1;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd5;

	// Headings
	localparam logic [1:0] HD_NORTH = 2'd0;
	localparam logic [1:0] HD_EAST  = 2'd1;
	localparam logic [1:0] HD_SOUTH = 2'd2;
	localparam logic [1:0] HD_WEST  = 2'd3;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BLOCKED = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_INDEX,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [1:0]         dir;
	} pose_t;

endpackage

// ===== hdl/grid_turtle_interpreter.sv =====
// ----------------------------------------------------------------------------
// grid_turtle_interpreter
// Turtle-graphics interpreter on a bounded grid: one symbol per transaction,
// painted segment cells or a single pose/status transaction out.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and holds in_stall high until its
// final result has been loaded into the output register; the next symbol may
// then be taken while that result still waits downstream. A symbol is decoded
// in the execute state, the row-times-width product of the first emitted cell
// is formed in the index state, and results leave one per cycle from the
// output register while the output is not stalled. A good pop also passes
// through the pop state between these, since the pose store is a memory with
// a registered read port. A good forward move emits every cell of its segment
// in turn: its cells are stepped one at a time, the linear index of each cell
// following from the previous one by adding 1 (horizontal segments) or the
// grid width (vertical segments). Output stalls hold the emission.
// Configuration writes are always taken and should be issued only while the
// block is idle. Widths and heights outside 1..256 are saturated; the pose
// stack holds 16 poses and is not cleared by reset.
// ----------------------------------------------------------------------------
module grid_turtle_interpreter
	import gti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// symbol channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [7:0]            symbol,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_W-1:0]    cell_x,
	output logic [COORD_W-1:0]    cell_y,
	output logic [INDEX_W-1:0]    cell_index,
	output logic                  painted,
	output logic [2:0]            status,
	output logic [1:0]            heading,
	output logic                  last,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [SIDE_W-1:0]  grid_width_q;
	logic [SIDE_W-1:0]  grid_height_q;
	logic [STEP_W-1:0]  step_length_q;
	logic [COORD_W-1:0] start_x_q;
	logic [COORD_W-1:0] start_y_q;
	logic [1:0]         start_heading_q;

	// turtle state
	logic [COORD_W-1:0] pos_x_q;
	logic [COORD_W-1:0] pos_y_q;
	logic [1:0]         dir_q;
	logic [CNT_W-1:0]   stack_count_q;

	// sequencer
	fsm_t               state_q;
	fsm_t               state_d;
	logic               cmd_q;
	logic [7:0]         sym_q;
	status_t            status_q;
	logic               seg_q;      // current transaction draws a segment
	logic               vert_q;     // segment runs along y
	logic [STEP_W-1:0]  cnt_q;

	// emission datapath
	logic [COORD_W-1:0] cur_x_q;
	logic [COORD_W-1:0] cur_y_q;
	logic [INDEX_W-1:0] idx_q;

	// pose store
	pose_t              stack_mem [STACK_DEPTH];
	pose_t              pop_rd_q;

	// output register
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic               out_painted_q;
	status_t            out_status_q;
	logic [1:0]         out_heading_q;
	logic               out_last_q;

	// ------------------------------------------------------------------------
	// Combinational decode
	// ------------------------------------------------------------------------
	logic [SIDE_W-1:0]  w_eff;
	logic [SIDE_W-1:0]  h_eff;
	logic signed [9:0]  nx;
	logic signed [9:0]  ny;
	logic signed [9:0]  step_s;
	logic               move_ok;
	logic               is_fwd;
	logic               is_push;
	logic               is_pop;
	logic               pop_ok;
	logic               push_ok;
	logic               out_free;
	logic               emit_last;
	logic               in_take;
	logic [16:0]        row_prod;
	logic [COORD_W-1:0] src_x;
	logic [COORD_W-1:0] src_y;

	// saturate the grid size to 1..MAX_SIDE
	always_comb begin
		if (grid_width_q == '0) begin
			w_eff = SIDE_W'(1);
		end else if (grid_width_q > SIDE_W'(MAX_SIDE)) begin
			w_eff = SIDE_W'(MAX_SIDE);
		end else begin
			w_eff = grid_width_q;
		end
		if (grid_height_q == '0) begin
			h_eff = SIDE_W'(1);
		end else if (grid_height_q > SIDE_W'(MAX_SIDE)) begin
			h_eff = SIDE_W'(MAX_SIDE);
		end else begin
			h_eff = grid_height_q;
		end
	end

	// target of a forward move along the current heading
	always_comb begin
		step_s = $signed({4'b0, step_length_q});
		nx     = $signed({2'b0, pos_x_q});
		ny     = $signed({2'b0, pos_y_q});
		case (dir_q)
			HD_NORTH: ny = $signed({2'b0, pos_y_q}) - step_s;
			HD_EAST:  nx = $signed({2'b0, pos_x_q}) + step_s;
			HD_SOUTH: ny = $signed({2'b0, pos_y_q}) + step_s;
			HD_WEST:  nx = $signed({2'b0, pos_x_q}) - step_s;
			default:  nx = $signed({2'b0, pos_x_q});
		endcase
	end

	// a saturated side never exceeds MAX_SIDE, so below it also means below 256
	assign move_ok = (nx >= 0) && (nx < $signed({1'b0, w_eff}))
	              && (ny >= 0) && (ny < $signed({1'b0, h_eff}));

	assign is_fwd  = (cmd_q == CMD_INTERPRET) && (sym_q == SYM_FWD);
	assign is_push = (cmd_q == CMD_INTERPRET) && (sym_q == SYM_PUSH);
	assign is_pop  = (cmd_q == CMD_INTERPRET) && (sym_q == SYM_POP);
	assign push_ok = is_push && (stack_count_q < CNT_W'(STACK_DEPTH));
	assign pop_ok  = is_pop && (stack_count_q != '0);

	assign out_free  = !out_valid_q || !out_stall;
	assign emit_last = !seg_q || (cnt_q == step_length_q);

	// first cell of the emission: the segment start, or the turtle itself
	assign src_x    = seg_q ? cur_x_q : pos_x_q;
	assign src_y    = seg_q ? cur_y_q : pos_y_q;
	assign row_prod = 17'(src_y) * 17'(w_eff);

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = pop_ok ? S_POP : S_INDEX;
			end
			S_POP: begin
				state_d = S_INDEX;
			end
			S_INDEX: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free && emit_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		cfg_ready = 1'b1;
	end

	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q    <= SIDE_W'(MAX_SIDE);
			grid_height_q   <= SIDE_W'(MAX_SIDE);
			step_length_q   <= STEP_W'(1);
			start_x_q       <= '0;
			start_y_q       <= '0;
			start_heading_q <= HD_NORTH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_WIDTH:    grid_width_q    <= cfg_data;
				CFG_GRID_HEIGHT:   grid_height_q   <= cfg_data;
				CFG_STEP_LENGTH:   step_length_q   <= cfg_data[STEP_W-1:0];
				CFG_START_X:       start_x_q       <= cfg_data[COORD_W-1:0];
				CFG_START_Y:       start_y_q       <= cfg_data[COORD_W-1:0];
				CFG_START_HEADING: start_heading_q <= cfg_data[1:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Turtle state and control of the running transaction
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			dir_q         <= HD_NORTH;
			stack_count_q <= '0;
			cmd_q         <= CMD_INTERPRET;
			sym_q         <= '0;
			status_q      <= ST_OK;
			seg_q         <= 1'b0;
			vert_q        <= 1'b0;
			cnt_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// capture the symbol transaction
					if (in_take) begin
						cmd_q <= cmd;
						sym_q <= symbol;
					end
				end
				S_EXEC: begin
					seg_q    <= 1'b0;
					cnt_q    <= '0;
					status_q <= ST_OK;
					if (cmd_q == CMD_RESTART) begin
						pos_x_q       <= start_x_q;
						pos_y_q       <= start_y_q;
						dir_q         <= start_heading_q;
						stack_count_q <= '0;
					end else if (is_fwd) begin
						if (move_ok) begin
							pos_x_q <= nx[COORD_W-1:0];
							pos_y_q <= ny[COORD_W-1:0];
							seg_q   <= 1'b1;
							vert_q  <= ~dir_q[0];
						end else begin
							status_q <= ST_BLOCKED;
						end
					end else if (sym_q == SYM_LEFT) begin
						dir_q <= dir_q - 2'd1;
					end else if (sym_q == SYM_RIGHT) begin
						dir_q <= dir_q + 2'd1;
					end else if (is_push) begin
						if (push_ok) begin
							stack_count_q <= stack_count_q + CNT_W'(1);
						end else begin
							status_q <= ST_FULL;
						end
					end else if (is_pop) begin
						if (pop_ok) begin
							stack_count_q <= stack_count_q - CNT_W'(1);
						end else begin
							status_q <= ST_EMPTY;
						end
					end else begin
						status_q <= ST_UNKNOWN;
					end
				end
				S_POP: begin
					// restore the pose read from the store
					pos_x_q <= pop_rd_q.x;
					pos_y_q <= pop_rd_q.y;
					dir_q   <= pop_rd_q.dir;
				end
				S_EMIT: begin
					if (out_free && !emit_last) begin
						cnt_q <= cnt_q + STEP_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Pose store: one write port, one registered read port
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && push_ok) begin
			stack_mem[stack_count_q[SP_W-1:0]] <= '{x: pos_x_q, y: pos_y_q, dir: dir_q};
		end
		if (state_q == S_EXEC) begin
			pop_rd_q <= stack_mem[SP_W'(stack_count_q - CNT_W'(1))];
		end
	end

	// ------------------------------------------------------------------------
	// Cell walker: start point, index and per-cell increment
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: begin
				// low end of the segment: only north and west moves start at the target
				cur_x_q <= (dir_q == HD_WEST)  ? nx[COORD_W-1:0] : pos_x_q;
				cur_y_q <= (dir_q == HD_NORTH) ? ny[COORD_W-1:0] : pos_y_q;
			end
			S_INDEX: begin
				cur_x_q <= src_x;
				cur_y_q <= src_y;
				idx_q   <= row_prod[INDEX_W-1:0] + INDEX_W'(src_x);
			end
			S_EMIT: begin
				if (out_free && !emit_last) begin
					if (vert_q) begin
						cur_y_q <= cur_y_q + COORD_W'(1);
						idx_q   <= idx_q + INDEX_W'(w_eff);
					end else begin
						cur_x_q <= cur_x_q + COORD_W'(1);
						idx_q   <= idx_q + INDEX_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_x_q       <= cur_x_q;
			out_y_q       <= cur_y_q;
			out_idx_q     <= idx_q;
			out_painted_q <= seg_q;
			out_status_q  <= status_q;
			out_heading_q <= dir_q;
			out_last_q    <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_x     = out_x_q;
	assign cell_y     = out_y_q;
	assign cell_index = out_idx_q;
	assign painted    = out_painted_q;
	assign status     = out_status_q;
	assign heading    = out_heading_q;
	assign last       = out_last_q;

endmodule

// ===== tb/sv/grid_turtle_interpreter_test.sv =====
// ----------------------------------------------------------------------------
// grid_turtle_interpreter_test
// Self-checking bench for the grid turtle interpreter. A turtle tracker keeps
// its own pose, heading and pose stack and predicts every painted cell and
// pose/status transaction. Symbols go in and results come out under random
// gaps and stalls, across several grid, step and start-pose settings.
// ----------------------------------------------------------------------------
module grid_turtle_interpreter_test;
	import gti_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 11;
	localparam int SETTLE       = 8;       // idle cycles after the last result
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
	localparam int LIMIT_CYCLES = 4000000;
	localparam int PHASES       = 7;

	// One expected result transaction
	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [INDEX_W-1:0] idx;
		logic               painted;
		status_t            st;
		logic [1:0]         hd;
		logic               last;
	} turtle_out_t;

	// Turtle tracker: mirrors the interpreter state and holds the results due
	class turtle_tracker;
		logic [SIDE_W-1:0]  width_reg;
		logic [SIDE_W-1:0]  height_reg;
		logic [STEP_W-1:0]  step_reg;
		logic [COORD_W-1:0] home_x;
		logic [COORD_W-1:0] home_y;
		logic [1:0]         home_hd;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [1:0]         hd;
		pose_t              saved [STACK_DEPTH];
		int                 depth;
		turtle_out_t        cells_due [$];
		int                 errors;

		function new();
			width_reg  = 9'd256;
			height_reg = 9'd256;
			step_reg   = 6'd1;
			home_x     = '0;
			home_y     = '0;
			home_hd    = HD_NORTH;
			px         = '0;
			py         = '0;
			hd         = HD_NORTH;
			depth      = 0;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_GRID_WIDTH:    width_reg  = data;
				CFG_GRID_HEIGHT:   height_reg = data;
				CFG_STEP_LENGTH:   step_reg   = data[STEP_W-1:0];
				CFG_START_X:       home_x     = data[COORD_W-1:0];
				CFG_START_Y:       home_y     = data[COORD_W-1:0];
				CFG_START_HEADING: home_hd    = data[1:0];
				default: ;
			endcase
		endfunction

		// Clamp a grid side into 1..MAX_SIDE
		function int side_of(logic [SIDE_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_SIDE)
				return MAX_SIDE;
			return v;
		endfunction

		function bit on_grid(int v, int lim);
			return v >= 0 && v < lim && v <= 255;
		endfunction

		function void add_result(int x, int y, logic p, status_t st, logic l);
			turtle_out_t r;
			logic [31:0] lin;
			lin       = y * side_of(width_reg) + x;
			r.x       = x[COORD_W-1:0];
			r.y       = y[COORD_W-1:0];
			r.idx     = lin[INDEX_W-1:0];
			r.painted = p;
			r.st      = st;
			r.hd      = hd;
			r.last    = l;
			cells_due.push_back(r);
		endfunction

		// Forward move: a blocked end point leaves the pose alone, otherwise
		// every cell of the segment is painted from low to high coordinate
		function void step_forward();
			int nx, ny, ox, oy, len, lo;
			len = step_reg;
			ox  = px;
			oy  = py;
			nx  = ox;
			ny  = oy;
			case (hd)
				HD_NORTH: ny = oy - len;
				HD_EAST:  nx = ox + len;
				HD_SOUTH: ny = oy + len;
				default:  nx = ox - len;
			endcase
			if (!on_grid(nx, side_of(width_reg)) || !on_grid(ny, side_of(height_reg))) begin
				add_result(ox, oy, 1'b0, ST_BLOCKED, 1'b1);
				return;
			end
			px = nx[COORD_W-1:0];
			py = ny[COORD_W-1:0];
			if (nx == ox) begin
				lo = (oy < ny) ? oy : ny;
				for (int i = 0; i <= len; i++)
					add_result(nx, lo + i, 1'b1, ST_OK, i == len);
			end else begin
				lo = (ox < nx) ? ox : nx;
				for (int i = 0; i <= len; i++)
					add_result(lo + i, ny, 1'b1, ST_OK, i == len);
			end
		endfunction

		function void note_symbol(logic c, logic [7:0] s);
			status_t st;
			pose_t   p;
			st = ST_OK;
			if (c == CMD_RESTART) begin
				px    = home_x;
				py    = home_y;
				hd    = home_hd;
				depth = 0;
			end else begin
				case (s)
					SYM_FWD: begin
						step_forward();
						return;
					end
					SYM_LEFT:  hd = hd + 2'd3;
					SYM_RIGHT: hd = hd + 2'd1;
					SYM_PUSH: begin
						if (depth >= STACK_DEPTH) begin
							st = ST_FULL;
						end else begin
							saved[depth] = {px, py, hd};
							depth++;
						end
					end
					SYM_POP: begin
						if (depth == 0) begin
							st = ST_EMPTY;
						end else begin
							depth--;
							p  = saved[depth];
							px = p.x;
							py = p.y;
							hd = p.dir;
						end
					end
					default: st = ST_UNKNOWN;
				endcase
			end
			add_result(px, py, 1'b0, st, 1'b1);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_cell(logic [7:0] x, logic [7:0] y, logic [15:0] idx,
				logic p, logic [2:0] st, logic [1:0] h, logic l);
			turtle_out_t want;
			if (cells_due.size() == 0) begin
				$error("unexpected result: x %0d y %0d status %0d", x, y, st);
				errors++;
				return;
			end
			want = cells_due.pop_front();
			compare_field("cell_x", want.x, x);
			compare_field("cell_y", want.y, y);
			compare_field("cell_index", want.idx, idx);
			compare_field("painted", want.painted, p);
			compare_field("status", want.st, st);
			compare_field("heading", want.hd, h);
			compare_field("last", want.last, l);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  cmd        = CMD_INTERPRET;
	logic [7:0]            symbol     = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [COORD_W-1:0]    cell_x;
	logic [COORD_W-1:0]    cell_y;
	logic [INDEX_W-1:0]    cell_index;
	logic                  painted;
	logic [2:0]            status;
	logic [1:0]            heading;
	logic                  last;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = CFG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	turtle_tracker tracker = new();

	bit gap_mode     = 1'b1;   // clear for back-to-back symbols
	bit hold_off_req = 1'b0;   // ask the receiver for one long hold-off

	// Settings per phase: width, height, step, start x, start y, start heading.
	// Zero and oversized sides exercise the clamp; the last phase is random.
	logic [CFG_DATA_W-1:0] plan [PHASES][6] = '{
		'{9'd16,  9'd16,  9'd3,  9'd8,   9'd8,   HD_EAST},
		'{9'd256, 9'd256, 9'd63, 9'd128, 9'd128, HD_SOUTH},
		'{9'd0,   9'd0,   9'd0,  9'd0,   9'd0,   HD_WEST},
		'{9'd511, 9'd300, 9'd5,  9'd255, 9'd255, HD_NORTH},
		'{9'd7,   9'd200, 9'd2,  9'd250, 9'd3,   HD_EAST},
		'{9'd256, 9'd1,   9'd1,  9'd0,   9'd0,   HD_EAST},
		'{9'd0,   9'd0,   9'd0,  9'd0,   9'd0,   HD_NORTH}
	};
	int run_len [PHASES] = '{55, 40, 30, 55, 30, 55, 65};

	grid_turtle_interpreter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_index (cell_index),
		.painted    (painted),
		.status     (status),
		.heading    (heading),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: give up well beyond the slowest legal run
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// Check every result transaction against the oldest prediction. Values
	// read here are those just before the edge, so no ordering race arises.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_cell(cell_x, cell_y, cell_index, painted, status, heading, last);
	end

	// Receiver: free-running stretches, short stalls and the odd long one.
	// On request, hold off for a long stretch so the block backs up.
	initial begin
		int unsigned pick;
		forever begin
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_stall <= 1'b0;
				pick = $urandom_range(0, 9);
				repeat ((pick == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12))
					@(posedge clk);
				pick = $urandom_range(0, 19);
				if (pick >= 4) begin
					out_stall <= 1'b1;
					if (pick >= 18)
						repeat ($urandom_range(8, 24)) @(posedge clk);
					else
						repeat ($urandom_range(1, 3)) @(posedge clk);
				end
			end
		end
	end

	// Offer one symbol, hold it until taken, then maybe leave a gap.
	// Valid stays high between back-to-back transactions.
	task automatic offer(input logic c, input logic [7:0] s);
		int unsigned r, pause;
		in_valid <= 1'b1;
		cmd      <= c;
		symbol   <= s;
		do @(posedge clk); while (in_stall);
		tracker.note_symbol(c, s);
		pause = 0;
		if (gap_mode) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				pause = $urandom_range(6, 30);
			else if (r >= 55)
				pause = $urandom_range(1, 3);
		end
		if (pause != 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every predicted result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.cells_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write; valid is left high for the next write
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic load_setup(input int ph);
		reg_write(CFG_GRID_WIDTH, plan[ph][0]);
		reg_write(CFG_GRID_HEIGHT, plan[ph][1]);
		reg_write(CFG_STEP_LENGTH, plan[ph][2]);
		reg_write(CFG_START_X, plan[ph][3]);
		reg_write(CFG_START_Y, plan[ph][4]);
		reg_write(CFG_START_HEADING, plan[ph][5]);
		cfg_valid <= 1'b0;
	endtask

	// Mostly real turtle symbols with moves favoured; the rest restarts and junk
	task automatic random_item();
		int unsigned r;
		logic [7:0]  s;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			offer(CMD_INTERPRET, SYM_FWD);
		end else if (r < 50) begin
			offer(CMD_INTERPRET, SYM_LEFT);
		end else if (r < 60) begin
			offer(CMD_INTERPRET, SYM_RIGHT);
		end else if (r < 72) begin
			offer(CMD_INTERPRET, SYM_PUSH);
		end else if (r < 84) begin
			offer(CMD_INTERPRET, SYM_POP);
		end else if (r < 88) begin
			offer(CMD_RESTART, 8'($urandom));
		end else begin
			do s = 8'($urandom);
			while (s inside {SYM_FWD, SYM_LEFT, SYM_RIGHT, SYM_PUSH, SYM_POP});
			offer(CMD_INTERPRET, s);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run on the reset settings: 256 x 256, step 1, origin, north
		offer(CMD_INTERPRET, SYM_FWD);     // off the top edge: blocked
		offer(CMD_INTERPRET, SYM_POP);     // nothing saved yet
		offer(CMD_INTERPRET, SYM_RIGHT);
		offer(CMD_INTERPRET, SYM_FWD);     // two cells along row 0
		offer(CMD_INTERPRET, SYM_RIGHT);
		offer(CMD_INTERPRET, SYM_FWD);     // two cells down column 1
		offer(CMD_INTERPRET, SYM_PUSH);
		offer(CMD_INTERPRET, SYM_LEFT);
		offer(CMD_INTERPRET, SYM_FWD);
		offer(CMD_INTERPRET, SYM_POP);     // back to the saved pose
		offer(CMD_INTERPRET, SYM_LEFT);
		offer(CMD_INTERPRET, SYM_LEFT);
		offer(CMD_INTERPRET, SYM_LEFT);    // north to west wraps
		offer(CMD_INTERPRET, SYM_LEFT);
		offer(CMD_INTERPRET, 8'h00);       // junk at both ends of the byte
		offer(CMD_INTERPRET, 8'hFF);
		offer(CMD_INTERPRET, 8'h66);       // lower-case forward is junk too
		offer(CMD_RESTART, SYM_FWD);       // symbol ignored on restart
		offer(CMD_INTERPRET, SYM_FWD);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) begin
				for (int k = 0; k < 6; k++)
					plan[ph][k] = 9'($urandom);
			end
			load_setup(ph);
			// back-to-back symbols in one phase, gaps elsewhere
			gap_mode = (ph != 3);
			if (ph == 1)
				hold_off_req = 1'b1;
			offer(CMD_RESTART, 8'($urandom));
			for (int n = 0; n < run_len[ph]; n++) begin
				// pause the sender once per phase until everything is back
				if (n == 25)
					drain();
				// fill the pose stack past full, then pop it past empty
				if (n == 20 && (ph == 1 || ph == 2)) begin
					repeat (STACK_DEPTH + 2) offer(CMD_INTERPRET, SYM_PUSH);
					repeat (STACK_DEPTH + 2) offer(CMD_INTERPRET, SYM_POP);
				end
				random_item();
			end
			drain();
		end

		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
